// File: rtl/lcd_nibble_write_sequencer_defines.svh
// ----------------------------------------------------------------------------
// LCD nibble write sequencer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define LNWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LNWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lnws_pkg.sv
// ----------------------------------------------------------------------------
// LCD nibble write sequencer package
// Request codes, register indexes, reset values and the power-up tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnws_pkg;

  typedef enum logic [2:0] {
    FUNC_NIBBLE = 3'd0,
    FUNC_BYTE   = 3'd1,
    FUNC_CHAR   = 3'd2,
    FUNC_CURSOR = 3'd3,
    FUNC_INIT   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CFG_ENABLE_PULSE = 2'd0,
    CFG_CHAR_HOLD    = 2'd1,
    CFG_CURSOR_HOLD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StepW = 5;

  localparam logic [7:0]  EnablePulseRst = 8'd1;
  localparam logic [15:0] CharHoldRst    = 16'd46;
  localparam logic [15:0] CursorHoldRst  = 16'd50;
  localparam logic [15:0] PowerupWaitUs  = 16'd50000;

  localparam logic [1:0] AddrLine0 = 2'b10;
  localparam logic [1:0] AddrLine1 = 2'b11;

  localparam logic [StepW-1:0] LastNibble = 5'd1;
  localparam logic [StepW-1:0] LastByte   = 5'd3;
  localparam logic [StepW-1:0] LastInit   = 5'd28;

  // Power-up sequence, one entry per enable pulse.
  function automatic logic [3:0] init_nibble(input logic [3:0] p);
    logic [3:0] n;
    unique case (p)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5, 4'd7:       n = 4'h8;
      4'd9:             n = 4'h1;
      4'd11:            n = 4'h6;
      4'd13:            n = 4'hD;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] init_low_hold(input logic [3:0] p);
    logic [15:0] h;
    unique case (p)
      4'd0:                    h = 16'd4100;
      4'd1, 4'd2, 4'd3:        h = 16'd100;
      4'd5, 4'd7, 4'd11, 4'd13: h = 16'd53;
      4'd9:                    h = 16'd3000;
      default:                 h = 16'd0;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// LCD nibble write sequencer
// Expands one request into the pin states of a 4-bit character LCD.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. It then holds
// busy_o high while its steps run: a nibble command gives 2 results, a byte,
// character or cursor move 4 and init 29. A step counter walks the request
// one pin state per cycle through a single shared lookup and select path;
// each state appears in the next cycle on the registered result ports for
// exactly one cycle with result_valid_o high, and last_o marks the final
// state. The receiver cannot stall, so every state must be taken when shown.
// Codes 5 to 7 on func_i are dropped and give no results. The configuration
// port is always ready; write it only while busy_o is low.
`timescale 1ns / 1ps

`include "lcd_nibble_write_sequencer_defines.svh"

module lcd_nibble_write_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [2:0]                     func_i,
  input  logic [7:0]                     value_i,
  input  logic [15:0]                    delay_us_i,
  input  logic                           row_i,
  input  logic [5:0]                     column_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lnws_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lnws_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           result_valid_o,
  output logic [3:0]                     data_nibble_o,
  output logic                           register_select_o,
  output logic                           enable_o,
  output logic [15:0]                    hold_us_o,
  output logic                           last_o
);

  import lnws_pkg::*;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] end_q, end_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] final_q, final_d;
  logic        rs_q, rs_d;
  logic        is_init_q, is_init_d;
  logic        is_nib_q, is_nib_d;

  logic [7:0]  enable_pulse_q;
  logic [15:0] char_hold_q;
  logic [15:0] cursor_hold_q;

  logic        res_valid_q;
  logic [3:0]  res_nib_q, res_nib_d;
  logic        res_rs_q;
  logic        res_en_q, res_en_d;
  logic [15:0] res_hold_q, res_hold_d;
  logic        res_last_q, res_last_d;

  logic             accept;
  logic             known;
  logic [StepW-1:0] pos;
  logic             last_step;

  assign busy_o      = (state_q == ST_RUN);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_pulse_q <= EnablePulseRst;
      char_hold_q    <= CharHoldRst;
      cursor_hold_q  <= CursorHoldRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ENABLE_PULSE: enable_pulse_q <= cfg_data_i[7:0];
        CFG_CHAR_HOLD:    char_hold_q    <= cfg_data_i;
        CFG_CURSOR_HOLD:  cursor_hold_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request decode
  always_comb begin
    known     = 1'b1;
    end_d     = LastByte;
    byte_d    = value_i;
    final_d   = delay_us_i;
    rs_d      = 1'b0;
    is_init_d = 1'b0;
    is_nib_d  = 1'b0;
    unique case (func_i)
      FUNC_NIBBLE: begin
        end_d    = LastNibble;
        is_nib_d = 1'b1;
      end
      FUNC_BYTE: ;
      FUNC_CHAR: begin
        rs_d    = 1'b1;
        final_d = char_hold_q;
      end
      FUNC_CURSOR: begin
        byte_d  = {(row_i ? AddrLine1 : AddrLine0), column_i};
        final_d = cursor_hold_q;
      end
      FUNC_INIT: begin
        end_d     = LastInit;
        is_init_d = 1'b1;
      end
      default: known = 1'b0;
    endcase
  end

  // Step sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept && known) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step_d = step_q + StepW'(1);
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Pin state of the current step
  assign last_step = (step_q == end_q);
  assign pos       = is_init_q ? (step_q - StepW'(1)) : step_q;

  always_comb begin
    res_en_d   = !pos[0];
    res_last_d = last_step;
    if (is_init_q) begin
      res_nib_d = init_nibble(pos[4:1]);
    end else if (is_nib_q || pos[1]) begin
      res_nib_d = byte_q[3:0];
    end else begin
      res_nib_d = byte_q[7:4];
    end
    priority if (is_init_q && step_q == '0) begin
      res_nib_d  = 4'h0;
      res_en_d   = 1'b0;
      res_hold_d = PowerupWaitUs;
    end else if (!pos[0]) begin
      res_hold_d = {8'd0, enable_pulse_q};
    end else if (is_init_q) begin
      res_hold_d = init_low_hold(pos[4:1]);
    end else if (last_step) begin
      res_hold_d = final_q;
    end else begin
      res_hold_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      res_valid_q <= busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known) begin
      end_q     <= end_d;
      byte_q    <= byte_d;
      final_q   <= final_d;
      rs_q      <= rs_d;
      is_init_q <= is_init_d;
      is_nib_q  <= is_nib_d;
    end
    if (busy_o) begin
      res_nib_q  <= res_nib_d;
      res_rs_q   <= rs_q;
      res_en_q   <= res_en_d;
      res_hold_q <= res_hold_d;
      res_last_q <= res_last_d;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign data_nibble_o     = res_nib_q;
  assign register_select_o = res_rs_q;
  assign enable_o          = res_en_q;
  assign hold_us_o         = res_hold_q;
  assign last_o            = res_last_q;

  `LNWS_ASSERT_NOW(a_last_frees, clk_i, rst_ni, result_valid_o && last_o, !busy_o, "busy after last")
  `LNWS_ASSERT_NEXT(a_run_emits, clk_i, rst_ni, busy_o, result_valid_o, "missing result")
  `LNWS_ASSERT_NEXT(a_start_runs, clk_i, rst_ni, start_i && !busy_o && (func_i <= FUNC_INIT), busy_o && !result_valid_o, "request not started")

endmodule
